// ===== hw/rtl/dtw_pkg.sv =====
// Shared types and constants for the DTW cost-matrix block.
// No dependencies.
package dtw_pkg;
  localparam int FEAT_W = 16;
  localparam int COST_W = 32;
  localparam logic [COST_W-1:0] COST_INF = '1;
  localparam int DIFF_W = 17;
  localparam int SQ_W = 34;     // |d|^2 fits 34 bits
  localparam int SUM_W = 36;    // three squares
  localparam int ROOT_W = 18;   // floor sqrt of 36 bits

  typedef enum logic [1:0] {
    DIR_UP   = 2'd0,
    DIR_LEFT = 2'd1,
    DIR_DIAG = 2'd2
  } dir_t;

  typedef struct packed {
    logic signed [FEAT_W-1:0] f0;
    logic signed [FEAT_W-1:0] f1;
    logic signed [FEAT_W-1:0] f2;
  } feat_vec_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIST = 4'b0010,
    ST_SQRT = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;
endpackage

// ===== hw/rtl/dtw_isqrt.sv =====
// Bit-serial floor square root, one result bit per cycle, ROOT_W result bits in all.
// Depends on dtw_pkg.
module dtw_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [dtw_pkg::SUM_W-1:0]   radicand,
  output logic                        done,
  output logic [dtw_pkg::ROOT_W-1:0]  root
);
  import dtw_pkg::*;

  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] res_r, res_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [SUM_W+1:0]  trial;
  logic [SUM_W+1:0]  bit_v;

  // classic restoring method: bit walks down two places per step
  always_comb begin
    bit_v = '0;
    bit_v[{cnt_r, 1'b0}] = 1'b1;
    trial = {2'b0, rem_r} - ({{(SUM_W+2-ROOT_W){1'b0}}, res_r} << ({1'b0, cnt_r} + 6'd1))
            - bit_v;
    rem_nxt = rem_r;
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (go) begin
      rem_nxt = radicand;
      res_nxt = '0;
      cnt_nxt = 5'(ROOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[SUM_W+1]) begin
        rem_nxt = trial[SUM_W-1:0];
        res_nxt = res_r | (ROOT_W'(1) << cnt_r);
      end
      if (cnt_r == '0) busy_nxt = 1'b0;
      else cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
  end

  assign done = busy_r && (cnt_r == '0);
  assign root = res_nxt;
endmodule

// ===== hw/rtl/dtw_cell.sv =====
// One cell of the cost chain: holds the previous-column cost of its row and
// shifts it to the neighbor when shift is high. Depends on dtw_pkg.
module dtw_cell (
  input  logic                       clk,
  input  logic                       load_start,
  input  logic [dtw_pkg::COST_W-1:0] start_val,
  input  logic                       shift,
  input  logic [dtw_pkg::COST_W-1:0] cost_in,
  output logic [dtw_pkg::COST_W-1:0] cost_out
);
  import dtw_pkg::*;

  logic [COST_W-1:0] cost_r;

  always_ff @(posedge clk) begin
    if (load_start) cost_r <= start_val;
    else if (shift) cost_r <= cost_in;
  end

  assign cost_out = cost_r;
endmodule

// ===== hw/rtl/dtw_cost_matrix_top.sv =====
// DTW cost-matrix block: reference store plus a rotating chain of cost cells.
// Reference append: handled in idle, busy stays low. Query: per reference row a
// distance state, the square-root states and an emit state; each result leaves on
// out_valid the cycle after its emit and cannot be stalled. Unless the store is full,
// busy then stays high while the chain rotates round to realign.
// Synchronous active-low reset clears the count and loads the start column.
module dtw_cost_matrix_top #(
  parameter int MAX_REF_LEN = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_func,
  input  logic                                 in_first,
  input  logic signed [dtw_pkg::FEAT_W-1:0]    in_feature_interval,
  input  logic signed [dtw_pkg::FEAT_W-1:0]    in_feature_duration,
  input  logic signed [dtw_pkg::FEAT_W-1:0]    in_feature_onset,
  output logic                                 out_valid,
  output logic [5:0]                           out_row_index,
  output logic [dtw_pkg::COST_W-1:0]           out_accumulated_cost,
  output logic [1:0]                           out_step_direction,
  output logic                                 out_last
);
  import dtw_pkg::*;

  localparam int AW = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
  localparam int CW = $clog2(MAX_REF_LEN + 1);
  localparam int NC = MAX_REF_LEN + 1;

  feat_vec_t         mem [MAX_REF_LEN];
  feat_vec_t         ref_rd_r;
  feat_vec_t         q_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     row_r;       // current row, 1-based
  state_t            state_r;
  logic [COST_W-1:0] up_r;
  logic [COST_W-1:0] chain [NC];
  logic [COST_W-1:0] diag_r;
  logic [COST_W-1:0] tail_in;
  logic              load_start, shift, drop_head, rot_all;
  logic              accept;
  logic              sq_go, sq_done;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] root_r;
  logic [CW-1:0]     rot_cnt_r;
  logic              rot_r;

  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE) || rot_r;

  // reset and a query with first both load the start column
  assign load_start = !rst_n || (accept && in_func && in_first);

  // ---- store
  always_ff @(posedge clk) begin
    if (accept && !in_func && (in_first || count_r < CW'(MAX_REF_LEN)))
      mem[in_first ? '0 : count_r[AW-1:0]] <=
        '{in_feature_interval, in_feature_duration, in_feature_onset};
    if (state_r == ST_IDLE || state_r == ST_EMIT)
      ref_rd_r <= mem[accept ? '0 : row_r[AW-1:0]];
  end

  // ---- distance
  logic signed [DIFF_W-1:0] d0, d1, d2;
  logic [SQ_W-1:0]          s0, s1, s2;
  logic [SUM_W-1:0]         sum_v;
  always_comb begin
    d0 = DIFF_W'(ref_rd_r.f0) - DIFF_W'(q_r.f0);
    d1 = DIFF_W'(ref_rd_r.f1) - DIFF_W'(q_r.f1);
    d2 = DIFF_W'(ref_rd_r.f2) - DIFF_W'(q_r.f2);
    s0 = SQ_W'(d0 * d0);
    s1 = SQ_W'(d1 * d1);
    s2 = SQ_W'(d2 * d2);
    sum_v = SUM_W'(s0) + SUM_W'(s1) + SUM_W'(s2);
  end

  assign sq_go = (state_r == ST_DIST);
  dtw_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .go(sq_go), .radicand(sum_v),
    .done(sq_done), .root(root)
  );

  // ---- cost selection; chain[0] = left (prev col, this row), diag_r = prev col, prev row
  logic [COST_W-1:0] left_v, best;
  dir_t              dir;
  logic [COST_W:0]   tot;
  logic [COST_W-1:0] cost;
  always_comb begin
    left_v = chain[0];
    best = up_r;
    dir = DIR_UP;
    if (left_v < best) begin best = left_v; dir = DIR_LEFT; end
    if (diag_r < best) begin best = diag_r; dir = DIR_DIAG; end
    tot = {1'b0, best} + (COST_W+1)'(root_r);
    if (best == COST_INF || tot >= {1'b0, COST_INF}) cost = COST_INF;
    else cost = tot[COST_W-1:0];
  end

  // The chain holds row r at cell 0 when processing row r. The first distance
  // cycle of a query rotates row zero out; it re-enters at the tail as infinity.
  // After the last row, rotate the untouched rows round to realign.
  assign shift = (state_r == ST_EMIT);
  assign drop_head = (state_r == ST_DIST) && (row_r == CW'(1));
  assign rot_all = shift || drop_head || rot_r;

  // chain rotates: cell 0 leaves, cell NC-1 takes new value
  always_comb begin
    if (shift) tail_in = cost;
    else if (drop_head) tail_in = COST_INF;
    else tail_in = chain[0];
  end

  genvar gi;
  generate
    for (gi = 0; gi < NC; gi++) begin : g_chain
      dtw_cell u_cell (
        .clk(clk), .load_start(load_start),
        .start_val((gi == 0) ? '0 : COST_INF),
        .shift(rot_all), .cost_in((gi == NC - 1) ? tail_in : chain[(gi + 1) % NC]),
        .cost_out(chain[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      rot_r <= 1'b0;
    end else begin
      if (rot_r) begin
        if (rot_cnt_r == '0) rot_r <= 1'b0;
        else rot_cnt_r <= rot_cnt_r - 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (!in_func) begin
              if (in_first) count_r <= CW'(1);
              else if (count_r < CW'(MAX_REF_LEN)) count_r <= count_r + 1'b1;
            end else if (count_r != '0) begin
              state_r <= ST_DIST;
            end
          end
        end
        ST_DIST: state_r <= ST_SQRT;
        ST_SQRT: if (sq_done) state_r <= ST_EMIT;
        ST_EMIT: begin
          if (row_r == count_r) begin
            state_r <= ST_IDLE;
            if (count_r != CW'(MAX_REF_LEN)) begin
              rot_r <= 1'b1;
              rot_cnt_r <= CW'(MAX_REF_LEN) - count_r - 1'b1;
            end
          end else begin
            state_r <= ST_DIST;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r <= '{in_feature_interval, in_feature_duration, in_feature_onset};
      row_r <= CW'(1);
      up_r <= COST_INF;                 // new row zero is infinity
      diag_r <= in_first ? '0 : chain[0];
    end
    if (sq_done) root_r <= root;
    if (state_r == ST_EMIT) begin
      up_r <= cost;
      diag_r <= chain[0];
      row_r <= row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= (state_r == ST_EMIT);
    if (state_r == ST_EMIT) begin
      out_row_index <= 6'(row_r);
      out_accumulated_cost <= cost;
      out_step_direction <= dir;
      out_last <= (row_r == count_r);
    end
  end

  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || !$past(in_func) || $past(count_r) == '0 || out_valid == 1'b0))
    else $error("busy not raised on query");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_REF_LEN)) else $error("count overflow");
  a_out_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row_index != 6'd0 || MAX_REF_LEN == 64)
    else $error("row zero emitted");
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for dtw_cost_matrix_top: drives reference and query items,
// predicts each DTW column and checks every emitted cell in order.
// Depends on dtw_pkg and the dtw_cost_matrix_top RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtw_pkg::*;

  localparam bit FN_APPEND = 1'b0;
  localparam bit FN_QUERY  = 1'b1;
  localparam int MAX_ROWS  = 32;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [5:0]        row;
    logic [COST_W-1:0] cost;
    dir_t              dir;
    logic              last;
  } cell_t;

  class dtw_scoreboard;
    logic signed [FEAT_W-1:0] ref_vec [MAX_ROWS][3];
    int unsigned              ref_len;
    logic [COST_W-1:0]        col [MAX_ROWS+1];
    cell_t                    pending_cells[$];
    int                       errors;

    function void clear_column();
      col[0] = '0;
      for (int i = 1; i <= MAX_ROWS; i++) col[i] = COST_INF;
    endfunction

    function new();
      ref_len = 0;
      errors = 0;
      clear_column();
    endfunction

    function longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        longint unsigned trial;
        trial = root | (64'd1 << b);
        if (trial * trial <= x) root = trial;
      end
      return root;
    endfunction

    function void note_item(bit func, bit first, logic signed [FEAT_W-1:0] q [3]);
      logic [COST_W-1:0] prev [MAX_ROWS+1];
      cell_t c;
      if (func == FN_APPEND) begin
        if (first) ref_len = 0;
        if (ref_len < MAX_ROWS) begin
          for (int k = 0; k < 3; k++) ref_vec[ref_len][k] = q[k];
          ref_len++;
        end
        return;
      end
      if (first) clear_column();
      if (ref_len == 0) return;
      prev = col;
      col[0] = COST_INF;
      for (int i = 1; i <= ref_len; i++) begin
        longint unsigned sum, total;
        logic [COST_W-1:0] best;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
          longint d;
          d = longint'(ref_vec[i-1][k]) - longint'(q[k]);
          if (d < 0) d = -d;
          sum += longint'(d) * longint'(d);
        end
        best = col[i-1];
        c.dir = DIR_UP;
        if (prev[i] < best) begin best = prev[i]; c.dir = DIR_LEFT; end
        if (prev[i-1] < best) begin best = prev[i-1]; c.dir = DIR_DIAG; end
        if (best == COST_INF) begin
          c.cost = COST_INF;
        end else begin
          total = longint'(best) + floor_sqrt(sum);
          c.cost = (total >= 64'hFFFF_FFFF) ? COST_INF : total[31:0];
        end
        col[i] = c.cost;
        c.row = i[5:0];
        c.last = (i == ref_len);
        pending_cells = {pending_cells, c};
      end
    endfunction

    function void check_result(logic [5:0] row, logic [COST_W-1:0] cost,
                               logic [1:0] dir, logic last);
      cell_t e;
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected cell row %0d cost %h dir %0d last %0b",
                 $time, row, cost, dir, last);
        errors++;
        return;
      end
      e = pending_cells.pop_front();
      if (row !== e.row) begin
        $display("%0t: row_index expected %0d actual %0d", $time, e.row, row);
        errors++;
      end
      if (cost !== e.cost) begin
        $display("%0t: row %0d cost expected %h actual %h", $time, e.row, e.cost, cost);
        errors++;
      end
      if (dir !== e.dir) begin
        $display("%0t: row %0d direction expected %0d actual %0d", $time, e.row, e.dir, dir);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: row %0d last expected %0b actual %0b", $time, e.row, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n, start, busy;
  logic in_func, in_first;
  logic signed [FEAT_W-1:0] in_feature_interval, in_feature_duration, in_feature_onset;
  logic out_valid, out_last;
  logic [5:0] out_row_index;
  logic [COST_W-1:0] out_accumulated_cost;
  logic [1:0] out_step_direction;

  dtw_scoreboard sb = new();
  bit calm;
  int cycles = 0;

  always #5 clk = ~clk;

  dtw_cost_matrix_top dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_row_index, out_accumulated_cost, out_step_direction, out_last);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(bit func, bit first, logic signed [FEAT_W-1:0] a,
                      logic signed [FEAT_W-1:0] b, logic signed [FEAT_W-1:0] c);
    logic signed [FEAT_W-1:0] q [3];
    q = '{a, b, c};
    start <= 1'b1;
    in_func <= func;
    in_first <= first;
    in_feature_interval <= a;
    in_feature_duration <= b;
    in_feature_onset <= c;
    do @(posedge clk); while (busy);
    sb.note_item(func, first, q);
    // random gap after the item
    if (!calm && $urandom_range(99) < 19) begin
      start <= 1'b0;
      in_func <= 1'($urandom_range(1));
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_cells.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // mostly values near zero so costs stay comparable, sometimes the full range
  function automatic logic signed [FEAT_W-1:0] pick_feat();
    if ($urandom_range(3) == 0) return 16'($urandom());
    return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
  endfunction

  task automatic rand_send(bit func, bit first);
    send(func, first, pick_feat(), pick_feat(), pick_feat());
  endtask

  initial begin
    int items, len;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_func <= 1'b0;
    in_first <= 1'b0;
    in_feature_interval <= '0;
    in_feature_duration <= '0;
    in_feature_onset <= '0;
    calm = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // queries against an empty store give no cells
    send(FN_QUERY, 1'b0, 16'sh0100, 16'sh0200, 16'sh0300);
    send(FN_QUERY, 1'b1, 16'sh0100, 16'sh0200, 16'sh0300);
    // field extremes and the largest local distance
    send(FN_APPEND, 1'b1, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send(FN_APPEND, 1'b0, 16'sh8000, 16'sh7FFF, 16'sh0000);
    send(FN_APPEND, 1'b0, 16'sh0000, 16'sh0000, 16'shFFFF);
    send(FN_QUERY, 1'b1, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send(FN_QUERY, 1'b0, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send(FN_QUERY, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000);
    // extend the store after a query: new rows start from infinity on the left
    send(FN_APPEND, 1'b0, 16'sh0001, 16'sh0002, 16'sh0003);
    send(FN_QUERY, 1'b0, 16'sh0001, 16'sh0002, 16'sh0003);
    // fill past capacity; the extra appends are dropped
    for (int i = 0; i < MAX_ROWS + 3; i++) rand_send(FN_APPEND, i == 0);
    send(FN_QUERY, 1'b1, 16'sh0000, 16'sh0000, 16'sh0000);
    rand_send(FN_QUERY, 1'b0);

    // hold the sender until every cell has come back
    drain();
    calm = 1'b0;

    items = 0;
    while (items < 75) begin
      calm = (items >= 20 && items < 50);
      if ($urandom_range(9) == 0) begin
        // noise: arbitrary func and first
        rand_send(1'($urandom_range(1)), 1'($urandom_range(1)));
        items++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, MAX_ROWS + 2)
                                       : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) rand_send(FN_APPEND, i == 0);
        items += len;
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) rand_send(FN_QUERY, i == 0 || $urandom_range(4) == 0);
        items += len;
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending_cells.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
